// ===== hdl/mwpid_pkg.sv =====
// ============================================================================
// mwpid_pkg
// Shared constants and request types of the mecanum wheel speed controller.
// ============================================================================
package mwpid_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_ROT    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_REAR_ROT     = 4'd7;

  // Serial multiplier: unsigned gain times unsigned magnitude
  localparam int unsigned MUL_GAIN_W = 32;
  localparam int unsigned MUL_MAG_W  = 33;
  localparam int unsigned MUL_PROD_W = MUL_GAIN_W + MUL_MAG_W;

  // Serial scaler: floor(a * lim / m)
  localparam int unsigned DIV_MAG_W = 47;
  localparam int unsigned DIV_LIM_W = 31;

  typedef struct packed {
    logic                  start;
    logic [MUL_GAIN_W-1:0] gain;
    logic [MUL_MAG_W-1:0]  mag;
  } mul_req_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_MAG_W-1:0] a;
    logic [DIV_LIM_W-1:0] lim;
    logic [DIV_MAG_W-1:0] m;
  } div_req_t;

endpackage

// ===== hdl/mwpid_cmd_if.sv =====
// ============================================================================
// mwpid_cmd_if
// Chassis target and measured wheel speed channel.
// ============================================================================
interface mwpid_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_vx;
  logic signed [31:0] target_vy;
  logic signed [31:0] target_wz;
  logic signed [31:0] meas_speed_0;
  logic signed [31:0] meas_speed_1;
  logic signed [31:0] meas_speed_2;
  logic signed [31:0] meas_speed_3;

  modport source (output valid, target_vx, target_vy, target_wz, meas_speed_0,
                  meas_speed_1, meas_speed_2, meas_speed_3, input ready);
  modport sink   (input valid, target_vx, target_vy, target_wz, meas_speed_0,
                  meas_speed_1, meas_speed_2, meas_speed_3, output ready);
endinterface

// ===== hdl/mwpid_drv_if.sv =====
// ============================================================================
// mwpid_drv_if
// Wheel drive current channel.
// ============================================================================
interface mwpid_drv_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive_current_0;
  logic signed [15:0] drive_current_1;
  logic signed [15:0] drive_current_2;
  logic signed [15:0] drive_current_3;

  modport source (output valid, drive_current_0, drive_current_1, drive_current_2,
                  drive_current_3, input ready);
  modport sink   (input valid, drive_current_0, drive_current_1, drive_current_2,
                  drive_current_3, output ready);
endinterface

// ===== hdl/mwpid_cfg_if.sv =====
// ============================================================================
// mwpid_cfg_if
// Configuration register write channel.
// ============================================================================
interface mwpid_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/mwpid_mul.sv =====
// ============================================================================
// mwpid_mul
// Bit-serial shift-add multiplier, one gain bit per cycle, LSB first.
// ============================================================================
module mwpid_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mwpid_pkg::mul_req_t                 req_i,
  output logic                                done_o,
  output logic [mwpid_pkg::MUL_PROD_W-1:0]    prod_o
);

  localparam int unsigned GW = mwpid_pkg::MUL_GAIN_W;
  localparam int unsigned MW = mwpid_pkg::MUL_MAG_W;
  localparam int unsigned CW = $clog2(GW);

  logic [GW+MW-1:0] prod_q;
  logic [MW-1:0]    mag_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [MW:0]      sum;

  assign sum = {1'b0, prod_q[GW+MW-1:GW]} + (prod_q[0] ? {1'b0, mag_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(GW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift the partial product right, add the magnitude on a set gain bit
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= {{MW{1'b0}}, req_i.gain};
      mag_q  <= req_i.mag;
    end else if (busy_q) begin
      prod_q <= {sum, prod_q[GW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ===== hdl/mwpid_div.sv =====
// ============================================================================
// mwpid_div
// Bit-serial proportional scaler: floor(a * lim / m), one lim bit per cycle.
// ============================================================================
module mwpid_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mwpid_pkg::div_req_t              req_i,
  output logic                             done_o,
  output logic [mwpid_pkg::DIV_LIM_W-1:0]  quot_o
);

  localparam int unsigned AW = mwpid_pkg::DIV_MAG_W;
  localparam int unsigned LW = mwpid_pkg::DIV_LIM_W;
  localparam int unsigned CW = $clog2(LW);

  logic [AW-1:0] a_q, m_q, rem_q;
  logic [LW-1:0] lim_q;
  logic [LW:0]   quot_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [AW+1:0] rp, m1, m2, rnext;
  logic [1:0]    digit;

  // remainder stays below m; 2r + a stays below 3m
  always_comb begin
    rp = {1'b0, rem_q, 1'b0} + (lim_q[LW-1] ? {2'b00, a_q} : '0);
    m1 = {2'b00, m_q};
    m2 = {1'b0, m_q, 1'b0};
    if (rp >= m2) begin
      rnext = rp - m2;
      digit = 2'd2;
    end else if (rp >= m1) begin
      rnext = rp - m1;
      digit = 2'd1;
    end else begin
      rnext = rp;
      digit = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(LW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q    <= req_i.a;
      m_q    <= req_i.m;
      lim_q  <= req_i.lim;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rnext[AW-1:0];
      quot_q <= {quot_q[LW-1:0], 1'b0} + {{(LW-1){1'b0}}, digit};
      lim_q  <= {lim_q[LW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q[LW-1:0];

endmodule

// ===== hdl/mecanum_wheel_speed_pid_control.sv =====
// ============================================================================
// mecanum_wheel_speed_pid_control
// Mecanum wheel mixing, proportional speed limiting and four positional PIDs.
// ============================================================================
//
//   channel  dir  payload                                   transaction
//   cmd_i    in   vx, vy, wz, four measured wheel speeds     one control tick
//   drv_o    out  four signed 16-bit drive currents          one per tick
//   cfg_i    in   register index, 32-bit write data          one register write
//
// The one bit-serial multiplier does fourteen multiplies per tick: two rotation
// products, then P, I and D per wheel. When the wheel targets exceed the speed
// limit, each wheel target is also scaled in the bit-serial scaler.
// Reset clears the gains, sets both clamps to 32767 and the speed limit to
// 4.0, and zeroes the integrators and stored errors.
// A new tick is taken while the last result waits on drv_o; the finish step
// holds until the output register is free.
// ============================================================================
module mecanum_wheel_speed_pid_control (
  input  logic  clk_i,
  input  logic  rst_ni,
  mwpid_cmd_if.sink   cmd_i,
  mwpid_drv_if.source drv_o,
  mwpid_cfg_if.sink   cfg_i
);

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MULF = 4'd1;   // front rotation product
  localparam logic [3:0] ST_MULR = 4'd2;   // rear rotation product
  localparam logic [3:0] ST_MIX  = 4'd3;   // one wheel target per cycle
  localparam logic [3:0] ST_CHK  = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;   // scale each wheel target
  localparam logic [3:0] ST_ERR  = 4'd6;
  localparam logic [3:0] ST_MP   = 4'd7;
  localparam logic [3:0] ST_MI   = 4'd8;
  localparam logic [3:0] ST_INT  = 4'd9;
  localparam logic [3:0] ST_MD   = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;
  localparam logic [3:0] ST_FIN  = 4'd12;

  localparam logic signed [48:0] ERR_MAX = 49'sd2147483647;
  localparam logic signed [48:0] ERR_MIN = -49'sd2147483648;

  // configuration
  logic [31:0]        prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [14:0]        integ_limit_q, output_limit_q;
  logic [30:0]        speed_limit_q;
  logic signed [31:0] front_rot_q, rear_rot_q;

  // control
  logic [3:0] state_q, state_d;
  logic [1:0] wheel_q;
  logic       mul_run_q, div_run_q;
  logic       out_valid_q;
  logic       cmd_acc, out_free;

  // datapath
  logic signed [31:0] vx_q, vy_q, wz_q;
  logic signed [31:0] meas_q   [4];
  logic signed [47:0] rf_q, rr_q;
  logic signed [47:0] tgt_q    [4];
  logic [46:0]        max_q;
  logic signed [31:0] err_q;
  logic signed [32:0] ediff_q;
  logic signed [49:0] p_q, ip_q, d_q;
  logic signed [31:0] integ_q  [4];
  logic signed [31:0] prev_q   [4];
  logic signed [15:0] cur_q    [4];
  logic signed [15:0] out_q    [4];

  // unit handshakes
  mwpid_pkg::mul_req_t mul_req;
  mwpid_pkg::div_req_t div_req;
  logic                                mul_done, div_done;
  logic [mwpid_pkg::MUL_PROD_W-1:0]    mul_prod;
  logic [mwpid_pkg::DIV_LIM_W-1:0]     div_quot;
  logic                                mul_neg;
  logic signed [49:0]                  prod_sgn;

  assign cmd_acc  = cmd_i.valid && cmd_i.ready;
  assign out_free = !out_valid_q || drv_o.ready;
  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // --------------------------------------------------------------------------
  // Operand magnitudes
  // --------------------------------------------------------------------------
  logic [31:0] front_mag, rear_mag, wz_mag, err_mag;
  logic [32:0] ediff_mag;

  assign front_mag = front_rot_q[31] ? 32'(-front_rot_q) : 32'(front_rot_q);
  assign rear_mag  = rear_rot_q[31]  ? 32'(-rear_rot_q)  : 32'(rear_rot_q);
  assign wz_mag    = wz_q[31]        ? 32'(-wz_q)        : 32'(wz_q);
  assign err_mag   = err_q[31]       ? 32'(-err_q)       : 32'(err_q);
  assign ediff_mag = ediff_q[32]     ? 33'(-ediff_q)     : 33'(ediff_q);

  // Route the multiplier by phase; the operand registers stay put while it runs
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.gain  = '0;
    mul_req.mag   = '0;
    mul_neg       = 1'b0;
    case (state_q)
      ST_MULF: begin
        mul_req.gain = front_mag;
        mul_req.mag  = {1'b0, wz_mag};
        mul_neg      = front_rot_q[31] ^ wz_q[31];
      end
      ST_MULR: begin
        mul_req.gain = rear_mag;
        mul_req.mag  = {1'b0, wz_mag};
        mul_neg      = rear_rot_q[31] ^ wz_q[31];
      end
      ST_MP: begin
        mul_req.gain = prop_gain_q;
        mul_req.mag  = {1'b0, err_mag};
        mul_neg      = err_q[31];
      end
      ST_MI: begin
        mul_req.gain = integ_gain_q;
        mul_req.mag  = {1'b0, err_mag};
        mul_neg      = err_q[31];
      end
      ST_MD: begin
        mul_req.gain = deriv_gain_q;
        mul_req.mag  = ediff_mag;
        mul_neg      = ediff_q[32];
      end
      default: begin
      end
    endcase
    if ((state_q == ST_MULF || state_q == ST_MULR || state_q == ST_MP ||
         state_q == ST_MI || state_q == ST_MD) && !mul_run_q) begin
      mul_req.start = 1'b1;
    end
  end

  // Q16.16 product, truncated toward zero, sign restored
  assign prod_sgn = mul_neg ? -$signed({1'b0, mul_prod[64:16]})
                            :  $signed({1'b0, mul_prod[64:16]});

  mwpid_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // --------------------------------------------------------------------------
  // Mixing and scaling
  // --------------------------------------------------------------------------
  logic signed [47:0] vx48, vy48, tmix, tcur;
  logic [46:0]        tmix_mag, tcur_mag;

  assign vx48 = 48'(vx_q);
  assign vy48 = 48'(vy_q);

  always_comb begin
    case (wheel_q)
      2'd0:    tmix = -vx48 - vy48 + rf_q;
      2'd1:    tmix =  vx48 - vy48 + rf_q;
      2'd2:    tmix =  vx48 + vy48 + rr_q;
      2'd3:    tmix = -vx48 + vy48 + rr_q;
      default: tmix = '0;
    endcase
  end

  assign tmix_mag = tmix[47] ? 47'(-tmix) : 47'(tmix);
  assign tcur     = tgt_q[wheel_q];
  assign tcur_mag = tcur[47] ? 47'(-tcur) : 47'(tcur);

  assign div_req.start = (state_q == ST_DIV) && !div_run_q;
  assign div_req.a     = tcur_mag;
  assign div_req.lim   = speed_limit_q;
  assign div_req.m     = max_q;

  mwpid_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // --------------------------------------------------------------------------
  // Error, integrator and output clamps
  // --------------------------------------------------------------------------
  logic signed [48:0] ediff49;
  logic signed [31:0] err_sat;
  logic signed [50:0] isum, ilim;
  logic signed [31:0] integ_new;
  logic signed [51:0] osum, olim, oclamp;
  logic signed [31:0] o32, omag;
  logic [14:0]        cmag;
  logic signed [15:0] cur_new;

  // targets are within the speed limit here, so 49 bits hold the difference
  assign ediff49 = 49'(tcur) - 49'(meas_q[wheel_q]);

  always_comb begin
    if (ediff49 > ERR_MAX) begin
      err_sat = 32'sh7FFF_FFFF;
    end else if (ediff49 < ERR_MIN) begin
      err_sat = 32'sh8000_0000;
    end else begin
      err_sat = ediff49[31:0];
    end
  end

  assign isum = 51'(integ_q[wheel_q]) + 51'(ip_q);
  assign ilim = $signed({20'b0, integ_limit_q, 16'b0});

  always_comb begin
    if (isum > ilim) begin
      integ_new = ilim[31:0];
    end else if (isum < -ilim) begin
      integ_new = 32'(-ilim);
    end else begin
      integ_new = isum[31:0];
    end
  end

  assign osum = 52'(p_q) + 52'(integ_q[wheel_q]) + 52'(d_q);
  assign olim = $signed({21'b0, output_limit_q, 16'b0});

  always_comb begin
    if (osum > olim) begin
      oclamp = olim;
    end else if (osum < -olim) begin
      oclamp = -olim;
    end else begin
      oclamp = osum;
    end
  end

  // drop the fraction toward zero
  assign o32     = oclamp[31:0];
  assign omag    = o32[31] ? -o32 : o32;
  assign cmag    = omag[30:16];
  assign cur_new = o32[31] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (cmd_acc) state_d = ST_MULF;
      ST_MULF: if (mul_done) state_d = ST_MULR;
      ST_MULR: if (mul_done) state_d = ST_MIX;
      ST_MIX:  if (wheel_q == 2'd3) state_d = ST_CHK;
      ST_CHK: begin
        if (max_q > {16'b0, speed_limit_q}) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_ERR;
        end
      end
      ST_DIV:  if (div_done && wheel_q == 2'd3) state_d = ST_ERR;
      ST_ERR:  state_d = ST_MP;
      ST_MP:   if (mul_done) state_d = ST_MI;
      ST_MI:   if (mul_done) state_d = ST_INT;
      ST_INT:  state_d = ST_MD;
      ST_MD:   if (mul_done) state_d = ST_OUT;
      ST_OUT: begin
        if (wheel_q == 2'd3) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_ERR;
        end
      end
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control state, configuration and PID state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      wheel_q        <= '0;
      mul_run_q      <= 1'b0;
      div_run_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      prop_gain_q    <= '0;
      integ_gain_q   <= '0;
      deriv_gain_q   <= '0;
      integ_limit_q  <= 15'd32767;
      output_limit_q <= 15'd32767;
      speed_limit_q  <= 31'd262144;
      front_rot_q    <= '0;
      rear_rot_q     <= '0;
      for (int i = 0; i < 4; i++) begin
        integ_q[i] <= '0;
        prev_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;

      if (mul_req.start) begin
        mul_run_q <= 1'b1;
      end else if (mul_done) begin
        mul_run_q <= 1'b0;
      end
      if (div_req.start) begin
        div_run_q <= 1'b1;
      end else if (div_done) begin
        div_run_q <= 1'b0;
      end

      // wheel index wraps back to 0 at the end of each pass
      if (cmd_acc) begin
        wheel_q <= '0;
      end else if (state_q == ST_MIX || state_q == ST_OUT ||
                   (state_q == ST_DIV && div_done)) begin
        wheel_q <= wheel_q + 1'b1;
      end

      if (state_q == ST_ERR) begin
        prev_q[wheel_q] <= err_sat;
      end
      if (state_q == ST_INT) begin
        integ_q[wheel_q] <= integ_new;
      end

      // output register: load on finish, release on a taken transaction
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (drv_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          mwpid_pkg::CFG_PROP_GAIN:    prop_gain_q    <= cfg_i.data;
          mwpid_pkg::CFG_INTEG_GAIN:   integ_gain_q   <= cfg_i.data;
          mwpid_pkg::CFG_DERIV_GAIN:   deriv_gain_q   <= cfg_i.data;
          mwpid_pkg::CFG_INTEG_LIMIT:  integ_limit_q  <= cfg_i.data[14:0];
          mwpid_pkg::CFG_OUTPUT_LIMIT: output_limit_q <= cfg_i.data[14:0];
          mwpid_pkg::CFG_SPEED_LIMIT:  speed_limit_q  <= cfg_i.data[30:0];
          mwpid_pkg::CFG_FRONT_ROT:    front_rot_q    <= cfg_i.data;
          mwpid_pkg::CFG_REAR_ROT:     rear_rot_q     <= cfg_i.data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cmd_acc) begin
          vx_q      <= cmd_i.target_vx;
          vy_q      <= cmd_i.target_vy;
          wz_q      <= cmd_i.target_wz;
          meas_q[0] <= cmd_i.meas_speed_0;
          meas_q[1] <= cmd_i.meas_speed_1;
          meas_q[2] <= cmd_i.meas_speed_2;
          meas_q[3] <= cmd_i.meas_speed_3;
          max_q     <= '0;
        end
      end
      ST_MULF: if (mul_done) rf_q <= prod_sgn[47:0];
      ST_MULR: if (mul_done) rr_q <= prod_sgn[47:0];
      ST_MIX: begin
        tgt_q[wheel_q] <= tmix;
        if (tmix_mag > max_q) max_q <= tmix_mag;
      end
      ST_DIV: begin
        if (div_done) begin
          tgt_q[wheel_q] <= tcur[47] ? -48'(div_quot) : 48'(div_quot);
        end
      end
      ST_ERR: begin
        err_q   <= err_sat;
        ediff_q <= 33'(err_sat) - 33'(prev_q[wheel_q]);
      end
      ST_MP:  if (mul_done) p_q  <= prod_sgn;
      ST_MI:  if (mul_done) ip_q <= prod_sgn;
      ST_MD:  if (mul_done) d_q  <= prod_sgn;
      ST_OUT: cur_q[wheel_q] <= cur_new;
      ST_FIN: if (out_free) out_q <= cur_q;
      default: begin
      end
    endcase
  end

  assign drv_o.valid           = out_valid_q;
  assign drv_o.drive_current_0 = out_q[0];
  assign drv_o.drive_current_1 = out_q[1];
  assign drv_o.drive_current_2 = out_q[2];
  assign drv_o.drive_current_3 = out_q[3];

endmodule

// ===== hdl/mwpid_checker.sv =====
// ============================================================================
// mwpid_checker
// Port-level checks of the wheel speed controller, bound to the top level.
// ============================================================================
module mwpid_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cmd_valid_i,
  input logic               cmd_ready_i,
  input logic               drv_valid_i,
  input logic               drv_ready_i,
  input logic signed [15:0] drv_current_0_i,
  input logic               cfg_ready_i
);

  // a tick in progress blocks the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_i) |=> !cmd_ready_i)
    else $error("command taken while a tick is in progress");

  // a taken command does not raise the result valid straight away
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_i) |=> !$rose(drv_valid_i))
    else $error("result appeared right after its command");

  // register writes are never stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration channel stalled");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drv_valid_i && !drv_ready_i) |=> (drv_valid_i && $stable(drv_current_0_i)))
    else $error("stalled result changed");

endmodule

bind mecanum_wheel_speed_pid_control mwpid_checker u_mwpid_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cmd_valid_i     (cmd_i.valid),
  .cmd_ready_i     (cmd_i.ready),
  .drv_valid_i     (drv_o.valid),
  .drv_ready_i     (drv_o.ready),
  .drv_current_0_i (drv_o.drive_current_0),
  .cfg_ready_i     (cfg_i.ready)
);
